### design/mpq_pkg.sv
`default_nettype none

package mpq_pkg;

    localparam int CAPACITY_DEF = 16;
    localparam int PRIO_W       = 6;
    localparam int DATA_W       = 32;
    localparam int COUNT_W      = 5;
    localparam int STATUS_W     = 2;
    localparam logic [PRIO_W-1:0] PRIO_MAX = 6'd49;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef enum logic {
        CMD_ENQUEUE = 1'b0,
        CMD_DEQUEUE = 1'b1
    } t_command;

    typedef enum logic [1:0] {
        OP_HOLD   = 2'd0,
        OP_INSERT = 2'd1,
        OP_POP    = 2'd2
    } t_cell_op;

    typedef struct packed {
        logic              valid;
        logic [DATA_W-1:0] data;
        logic [PRIO_W-1:0] prio;
    } t_entry;

    typedef struct packed {
        t_cell_op          op;
        logic [DATA_W-1:0] data;
        logic [PRIO_W-1:0] prio;
    } t_cell_ctl;

endpackage

`default_nettype wire

### design/mpq_cell.sv
`default_nettype none

module mpq_cell (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire mpq_pkg::t_cell_ctl i_ctl,
    input  wire mpq_pkg::t_entry    i_left_ent,
    input  wire                  i_left_goes,
    input  wire mpq_pkg::t_entry    i_right_ent,
    output mpq_pkg::t_entry      o_ent,
    output logic                 o_goes
);

    logic                       r_valid;
    logic [mpq_pkg::DATA_W-1:0] r_data;
    logic [mpq_pkg::PRIO_W-1:0] r_prio;
    mpq_pkg::t_entry            n_ent;
    mpq_pkg::t_entry            w_new;

    assign o_ent.valid = r_valid;
    assign o_ent.data  = r_data;
    assign o_ent.prio  = r_prio;

    // this slot moves right on insert: empty, or not above the new priority
    // (newer entry wins ties, so it sits ahead of equals)
    assign o_goes = !r_valid || (r_prio <= i_ctl.prio);

    assign w_new.valid = 1'b1;
    assign w_new.data  = i_ctl.data;
    assign w_new.prio  = i_ctl.prio;

    always_comb begin
        n_ent = o_ent;
        case (i_ctl.op)
            mpq_pkg::OP_INSERT: begin
                if (o_goes) begin
                    n_ent = i_left_goes ? i_left_ent : w_new;
                end
            end
            mpq_pkg::OP_POP: begin
                n_ent = i_right_ent;
            end
            default: begin
                n_ent = o_ent;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_ent.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_ent.data;
        r_prio <= n_ent.prio;
    end

endmodule

`default_nettype wire

### design/max_priority_queue_core.sv
`default_nettype none

// Bounded max-priority queue built as a sorted shift chain of CAPACITY cells,
// highest priority at the head, newest first among equal priorities. For every
// item (enqueue or dequeue) all cells compare against the incoming priority
// and shift in parallel, so a new item is taken in every cycle while the
// output register is free or being drained. Each item yields one registered
// result in the next cycle with status, the removed entry on dequeue and
// the count after the item. Priorities above 49 are stored as 49; an enqueue
// into a full queue is dropped with full status, a dequeue of an empty queue
// returns empty status.
module max_priority_queue_core #(
    parameter int CAPACITY = mpq_pkg::CAPACITY_DEF
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_in_valid,
    output logic                           o_in_stall,
    input  wire                            i_command,
    input  wire signed [mpq_pkg::DATA_W-1:0] i_data,
    input  wire  [mpq_pkg::PRIO_W-1:0]     i_priority_req,
    output logic                           o_out_valid,
    input  wire                            i_out_stall,
    output logic [mpq_pkg::STATUS_W-1:0]   o_status,
    output logic signed [mpq_pkg::DATA_W-1:0] o_removed_data,
    output logic [mpq_pkg::PRIO_W-1:0]     o_removed_priority,
    output logic [mpq_pkg::COUNT_W-1:0]    o_count
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic                          w_accept;
    logic                          w_full;
    logic                          w_empty;
    logic [mpq_pkg::PRIO_W-1:0]    w_prio_sat;
    mpq_pkg::t_cell_ctl            w_ctl;
    mpq_pkg::t_entry               w_ent [CAPACITY+1];
    logic                          w_goes [CAPACITY+1];
    mpq_pkg::t_entry               w_left [CAPACITY];
    logic [CAPACITY-1:0]           w_valid_vec;

    logic [CNT_W-1:0]              r_count;
    logic [CNT_W-1:0]              n_count;
    logic                          r_out_valid;
    logic [mpq_pkg::STATUS_W-1:0]  r_status;
    logic [mpq_pkg::STATUS_W-1:0]  n_status;
    logic [mpq_pkg::DATA_W-1:0]    r_rdata;
    logic [mpq_pkg::DATA_W-1:0]    n_rdata;
    logic [mpq_pkg::PRIO_W-1:0]    r_rprio;
    logic [mpq_pkg::PRIO_W-1:0]    n_rprio;
    logic [mpq_pkg::COUNT_W-1:0]   r_count_out;

    assign o_in_stall = r_out_valid && i_out_stall;
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_full     = (r_count == CNT_W'(CAPACITY));
    assign w_empty    = (r_count == '0);
    assign w_prio_sat = (i_priority_req > mpq_pkg::PRIO_MAX) ? mpq_pkg::PRIO_MAX
                                                             : i_priority_req;

    always_comb begin
        w_ctl.op   = mpq_pkg::OP_HOLD;
        w_ctl.data = i_data;
        w_ctl.prio = w_prio_sat;
        n_count    = r_count;
        n_status   = mpq_pkg::ST_OK;
        n_rdata    = '0;
        n_rprio    = '0;
        if (i_command == mpq_pkg::CMD_ENQUEUE) begin
            if (w_full) begin
                n_status = mpq_pkg::ST_FULL;
            end else begin
                w_ctl.op = w_accept ? mpq_pkg::OP_INSERT : mpq_pkg::OP_HOLD;
                n_count  = r_count + CNT_W'(1);
            end
        end else begin
            if (w_empty) begin
                n_status = mpq_pkg::ST_EMPTY;
            end else begin
                w_ctl.op = w_accept ? mpq_pkg::OP_POP : mpq_pkg::OP_HOLD;
                n_count  = r_count - CNT_W'(1);
                n_rdata  = w_ent[0].data;
                n_rprio  = w_ent[0].prio;
            end
        end
    end

    assign w_goes[0]           = 1'b0;
    assign w_ent[CAPACITY]     = '0;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        if (g == 0) begin : g_head
            assign w_left[g] = '0;
        end else begin : g_body
            assign w_left[g] = w_ent[g-1];
        end
        assign w_valid_vec[g] = w_ent[g].valid;

        mpq_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (w_ctl),
            .i_left_ent  (w_left[g]),
            .i_left_goes (w_goes[g]),
            .i_right_ent (w_ent[g+1]),
            .o_ent       (w_ent[g]),
            .o_goes      (w_goes[g+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_status    <= n_status;
            r_rdata     <= n_rdata;
            r_rprio     <= n_rprio;
            r_count_out <= mpq_pkg::COUNT_W'(n_count);
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_status           = r_status;
    assign o_removed_data     = r_rdata;
    assign o_removed_priority = r_rprio;
    assign o_count            = r_count_out;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("count above capacity");

    a_valid_matches_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(w_valid_vec) == int'(r_count))
        else $error("cell valid bits disagree with count");

    a_head_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && (i_command == mpq_pkg::CMD_DEQUEUE) && !w_empty
        |=> o_out_valid && (o_status == mpq_pkg::ST_OK))
        else $error("dequeue of non-empty queue did not report ok");

endmodule

`default_nettype wire
